// File: rtl/ipv4_header_validator_core_assert.svh
// Assertion macros for the IPv4 header validator core.
// Each macro expects clk and rst_n in scope.
`ifndef IPV4_HEADER_VALIDATOR_CORE_ASSERT_SVH
`define IPV4_HEADER_VALIDATOR_CORE_ASSERT_SVH

// Same-cycle implication.
`define IHV_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define IHV_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ihv_pkg.sv
// ----------------------------------------------------------------------------
// ihv_pkg
// Shared types and constants for the IPv4 header validator.
// ----------------------------------------------------------------------------
package ihv_pkg;

  localparam int MIN_HEADER_BYTES = 20;
  localparam int QUEUE_DEPTH      = 2;

  localparam logic [3:0] IP_VERSION = 4'd4;
  localparam logic [3:0] IHL_MIN    = 4'd5;
  localparam logic [7:0] IHL_MASK   = 8'h0F;

  // header byte positions
  localparam logic [15:0] POS_VIHL   = 16'd0;
  localparam logic [15:0] POS_TOT_HI = 16'd2;
  localparam logic [15:0] POS_TOT_LO = 16'd3;
  localparam logic [15:0] POS_TTL    = 16'd8;
  localparam logic [15:0] POS_PROTO  = 16'd9;
  localparam logic [15:0] POS_CSUM_HI = 16'd10;
  localparam logic [15:0] POS_CSUM_LO = 16'd11;
  localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_UDP  = 8'd17;
  localparam logic [7:0] PROTO_TCP  = 8'd6;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_SHORT     = 4'd1,
    ST_VERSION   = 4'd2,
    ST_IHL       = 4'd3,
    ST_HDR_CUT   = 4'd4,
    ST_CHECKSUM  = 4'd5,
    ST_TRUNCATED = 4'd6,
    ST_TTL       = 4'd7,
    ST_PROTOCOL  = 4'd8
  } ihv_status_t;

  typedef enum logic [1:0] {
    PC_ICMP = 2'd0,
    PC_UDP  = 2'd1,
    PC_TCP  = 2'd2,
    PC_NONE = 2'd3
  } ihv_pclass_t;

  // one finished packet, handed from front to back
  typedef struct packed {
    logic [15:0] len;
    logic [7:0]  vihl;
    logic [20:0] sum;
    logic [15:0] csum;
    logic [15:0] tot_len;
    logic [7:0]  ttl;
    logic [7:0]  proto;
  } ihv_rec_t;

  typedef struct packed {
    logic valid;
    logic full;
  } ihv_qstat_t;

endpackage

// File: rtl/ihv_front.sv
// ----------------------------------------------------------------------------
// ihv_front
// Byte intake: counts bytes, captures header fields and keeps the running
// header sum. Emits one packet record on the last byte.
// ----------------------------------------------------------------------------
module ihv_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             take,
  input  logic [7:0]       data_byte,
  input  logic             last_byte,
  output logic             push,
  output ihv_pkg::ihv_rec_t rec
);

  logic [15:0] cnt_r, cnt_nxt;
  logic [7:0]  vihl_r, vihl_nxt;
  logic [20:0] sum_r, sum_nxt;
  logic [7:0]  hold_r, hold_nxt;
  logic [15:0] csum_r, csum_nxt;
  logic [15:0] tot_r, tot_nxt;
  logic [7:0]  ttl_r, ttl_nxt;
  logic [7:0]  proto_r, proto_nxt;

  logic [5:0]  hlen;
  logic [7:0]  v;

  always_comb begin
    vihl_nxt  = (cnt_r == ihv_pkg::POS_VIHL) ? data_byte : vihl_r;
    hlen      = {vihl_nxt[3:0], 2'b00};
    v         = (cnt_r == ihv_pkg::POS_CSUM_HI || cnt_r == ihv_pkg::POS_CSUM_LO) ?
                8'd0 : data_byte;
    hold_nxt  = hold_r;
    sum_nxt   = sum_r;
    if (cnt_r < {10'd0, hlen}) begin
      if (!cnt_r[0]) begin
        hold_nxt = v;
      end else begin
        sum_nxt = sum_r + {5'd0, hold_r, v};
      end
    end
    tot_nxt   = tot_r;
    ttl_nxt   = ttl_r;
    proto_nxt = proto_r;
    csum_nxt  = csum_r;
    if (cnt_r == ihv_pkg::POS_TOT_HI)  tot_nxt[15:8]  = data_byte;
    if (cnt_r == ihv_pkg::POS_TOT_LO)  tot_nxt[7:0]   = data_byte;
    if (cnt_r == ihv_pkg::POS_TTL)     ttl_nxt        = data_byte;
    if (cnt_r == ihv_pkg::POS_PROTO)   proto_nxt      = data_byte;
    if (cnt_r == ihv_pkg::POS_CSUM_HI) csum_nxt[15:8] = data_byte;
    if (cnt_r == ihv_pkg::POS_CSUM_LO) csum_nxt[7:0]  = data_byte;
    cnt_nxt = (cnt_r != ihv_pkg::COUNT_MAX) ? cnt_r + 16'd1 : cnt_r;

    rec.len     = cnt_nxt;
    rec.vihl    = vihl_nxt;
    rec.sum     = sum_nxt;
    rec.csum    = csum_nxt;
    rec.tot_len = tot_nxt;
    rec.ttl     = ttl_nxt;
    rec.proto   = proto_nxt;
    push        = take & last_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || push) begin
      cnt_r   <= '0;
      vihl_r  <= '0;
      sum_r   <= '0;
      hold_r  <= '0;
      csum_r  <= '0;
      tot_r   <= '0;
      ttl_r   <= '0;
      proto_r <= '0;
    end else if (take) begin
      cnt_r   <= cnt_nxt;
      vihl_r  <= vihl_nxt;
      sum_r   <= sum_nxt;
      hold_r  <= hold_nxt;
      csum_r  <= csum_nxt;
      tot_r   <= tot_nxt;
      ttl_r   <= ttl_nxt;
      proto_r <= proto_nxt;
    end
  end

endmodule

// File: rtl/ihv_queue.sv
// ----------------------------------------------------------------------------
// ihv_queue
// Short register FIFO of packet records between front and back.
// ----------------------------------------------------------------------------
module ihv_queue #(
  parameter int DEPTH = ihv_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ihv_pkg::ihv_rec_t push_rec,
  input  logic              pop,
  output ihv_pkg::ihv_rec_t pop_rec,
  output ihv_pkg::ihv_qstat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  ihv_pkg::ihv_rec_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt;
  logic [PTR_W-1:0] rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_nxt  = push ? ((wr_r == PTR_LAST) ? '0 : wr_r + 1'b1) : wr_r;
    rd_nxt  = pop  ? ((rd_r == PTR_LAST) ? '0 : rd_r + 1'b1) : rd_r;
    cnt_nxt = cnt_r + CNT_W'(push) - CNT_W'(pop);
    stat.valid = (cnt_r != '0);
    stat.full  = (cnt_r == CNT_FULL);
    pop_rec    = mem_r[rd_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_rec;
    end
  end

endmodule

// File: rtl/ihv_back.sv
// ----------------------------------------------------------------------------
// ihv_back
// Verdict stage: folds the header sum, runs the checks in order and holds
// the result in the output register.
// ----------------------------------------------------------------------------
module ihv_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  ihv_pkg::ihv_rec_t    q_rec,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ihv_pkg::ihv_status_t out_status,
  output ihv_pkg::ihv_pclass_t out_pclass,
  output logic [5:0]           out_hlen,
  output logic [15:0]          out_payload
);

  localparam logic [15:0] MIN_LEN = 16'(ihv_pkg::MIN_HEADER_BYTES);

  logic                 valid_r;
  ihv_pkg::ihv_status_t status_r, status_nxt;
  ihv_pkg::ihv_pclass_t pclass_r, pclass_nxt;
  logic [5:0]           hlen_r, hlen_nxt;
  logic [15:0]          payload_r, payload_nxt;

  logic [16:0] fold1;
  logic [15:0] fold2;
  logic [15:0] computed;
  logic [15:0] hlen_w;

  always_comb begin
    fold1    = {1'b0, q_rec.sum[15:0]} + {12'd0, q_rec.sum[20:16]};
    fold2    = fold1[15:0] + {15'd0, fold1[16]};
    computed = ~fold2;
    hlen_nxt = {q_rec.vihl[3:0], 2'b00};
    hlen_w   = {10'd0, hlen_nxt};

    unique case (q_rec.proto)
      ihv_pkg::PROTO_ICMP: pclass_nxt = ihv_pkg::PC_ICMP;
      ihv_pkg::PROTO_UDP:  pclass_nxt = ihv_pkg::PC_UDP;
      ihv_pkg::PROTO_TCP:  pclass_nxt = ihv_pkg::PC_TCP;
      default:             pclass_nxt = ihv_pkg::PC_NONE;
    endcase

    priority if (q_rec.len < MIN_LEN)             status_nxt = ihv_pkg::ST_SHORT;
    else if (q_rec.vihl[7:4] != ihv_pkg::IP_VERSION) status_nxt = ihv_pkg::ST_VERSION;
    else if (q_rec.vihl[3:0] < ihv_pkg::IHL_MIN)  status_nxt = ihv_pkg::ST_IHL;
    else if (q_rec.len < hlen_w)                  status_nxt = ihv_pkg::ST_HDR_CUT;
    else if (computed != q_rec.csum)              status_nxt = ihv_pkg::ST_CHECKSUM;
    else if (q_rec.tot_len > q_rec.len)           status_nxt = ihv_pkg::ST_TRUNCATED;
    else if (q_rec.ttl == 8'd0)                   status_nxt = ihv_pkg::ST_TTL;
    else if (pclass_nxt == ihv_pkg::PC_NONE)      status_nxt = ihv_pkg::ST_PROTOCOL;
    else                                          status_nxt = ihv_pkg::ST_OK;

    payload_nxt = (q_rec.tot_len >= hlen_w) ? q_rec.tot_len - hlen_w : 16'd0;
    q_pop       = q_valid && (!valid_r || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      status_r  <= status_nxt;
      pclass_r  <= pclass_nxt;
      hlen_r    <= hlen_nxt;
      payload_r <= payload_nxt;
    end
  end

  assign out_valid   = valid_r;
  assign out_status  = status_r;
  assign out_pclass  = pclass_r;
  assign out_hlen    = hlen_r;
  assign out_payload = payload_r;

endmodule

// File: rtl/ipv4_header_validator_core.sv
// Path: the last byte's record passes a queue slot, then the output register, where
// out_valid rises; a held verdict (out_stall) keeps the next record in the queue.
// Throughput: one byte per cycle unless in_stall, one verdict per cycle unless
// out_stall; in_stall rises only when the intake-to-verdict record queue is full.
// Reset: synchronous, active low; clears the byte counters, captured fields,
// queue and output valid. No clearing pass.
// ----------------------------------------------------------------------------
// ipv4_header_validator_core
// Validates an IPv4 header streamed one byte per request and reports a
// verdict, protocol class, header length and payload length per packet.
// ----------------------------------------------------------------------------
`include "ipv4_header_validator_core_assert.svh"

module ipv4_header_validator_core #(
  parameter int QUEUE_DEPTH = ihv_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_status,
  output logic [1:0]  out_protocol_class,
  output logic [5:0]  out_header_bytes,
  output logic [15:0] out_payload_length
);

  logic                 take;
  logic                 q_push;
  logic                 q_pop;
  ihv_pkg::ihv_rec_t    f_rec;
  ihv_pkg::ihv_rec_t    q_rec;
  ihv_pkg::ihv_qstat_t  q_stat;
  ihv_pkg::ihv_status_t b_status;
  ihv_pkg::ihv_pclass_t b_pclass;

  assign in_stall = q_stat.full;
  assign take     = in_valid && !in_stall;

  ihv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .push      (q_push),
    .rec       (f_rec)
  );

  ihv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_rec (f_rec),
    .pop      (q_pop),
    .pop_rec  (q_rec),
    .stat     (q_stat)
  );

  ihv_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_stat.valid),
    .q_rec       (q_rec),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_status  (b_status),
    .out_pclass  (b_pclass),
    .out_hlen    (out_header_bytes),
    .out_payload (out_payload_length)
  );

  assign out_status         = b_status;
  assign out_protocol_class = b_pclass;

  `IHV_ASSERT_IMP(a_no_overflow, q_push, !q_stat.full, "record pushed into full queue")
  `IHV_ASSERT_IMP(a_pop_valid, q_pop, q_stat.valid, "record popped from empty queue")
  `IHV_ASSERT_NXT(a_push_visible, q_push, q_stat.valid, "pushed record not visible")
  `IHV_ASSERT_IMP(a_ok_has_class, out_valid && b_status == ihv_pkg::ST_OK,
                  b_pclass != ihv_pkg::PC_NONE, "ok verdict without protocol class")

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Byte-stream testbench for ipv4_header_validator_core. Packets are fed one
// byte per request: a table of hand-built packets first, then random
// packets, mostly well-formed headers, some with options and payload, plus
// a share of broken ones. A byte-level model of the validator predicts each
// verdict; typed table rows override its status. Verdicts are compared field
// by field, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int RANDOM_BYTES = 780;
  localparam int CALM_BYTES   = 120;
  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int DRAIN_CYCLES = 8;

  typedef enum {FILL_RAND, FILL_ZERO, FILL_ONES} fill_t;
  typedef enum {CK_GOOD, CK_BAD, CK_ASIS} ck_t;

  typedef struct {
    int                   plen;
    logic [3:0]           ver;
    logic [3:0]           ihl;
    logic [15:0]          tot;
    logic [7:0]           ttl;
    logic [7:0]           proto;
    ck_t                  ck;
    fill_t                fill;
    bit                   typed;
    ihv_pkg::ihv_status_t st;
  } pkt_spec_t;

  typedef struct {
    ihv_pkg::ihv_status_t status;
    ihv_pkg::ihv_pclass_t pclass;
    logic [5:0]           hbytes;
    logic [15:0]          payload;
  } verdict_t;

  typedef struct {
    bit                   typed;
    ihv_pkg::ihv_status_t st;
  } pkt_note_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_last_byte;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  out_status;
  logic [1:0]  out_protocol_class;
  logic [5:0]  out_header_bytes;
  logic [15:0] out_payload_length;

  // predictor state
  logic [15:0] cnt_q;
  logic [7:0]  vihl_q;
  logic [20:0] sum_q;
  logic [7:0]  hold_q;
  logic [15:0] csum_q;
  logic [15:0] tot_q;
  logic [7:0]  ttl_q;
  logic [7:0]  proto_q;

  verdict_t  verdicts_due[$];
  pkt_note_t pkt_notes[$];

  int  errors;
  int  cycles;
  int  packets_sent;
  int  bytes_sent;
  int  verdicts_checked;
  int  status_seen[16];
  bit  calm;

  pkt_spec_t directed_rows[20] = '{
    '{1,  4, 5,  16'd20,   8'd64,  ihv_pkg::PROTO_TCP,  CK_ASIS, FILL_RAND, 1,
      ihv_pkg::ST_SHORT},
    '{19, 4, 5,  16'd19,   8'd64,  ihv_pkg::PROTO_TCP,  CK_GOOD, FILL_RAND, 1,
      ihv_pkg::ST_SHORT},
    '{20, 6, 5,  16'd20,   8'd64,  ihv_pkg::PROTO_TCP,  CK_GOOD, FILL_RAND, 1,
      ihv_pkg::ST_VERSION},
    '{20, 4, 0,  16'd20,   8'd64,  ihv_pkg::PROTO_UDP,  CK_GOOD, FILL_RAND, 1,
      ihv_pkg::ST_IHL},
    '{24, 4, 4,  16'd24,   8'd64,  ihv_pkg::PROTO_UDP,  CK_GOOD, FILL_RAND, 1,
      ihv_pkg::ST_IHL},
    '{40, 4, 15, 16'd40,   8'd64,  ihv_pkg::PROTO_TCP,  CK_GOOD, FILL_RAND, 1,
      ihv_pkg::ST_HDR_CUT},
    '{60, 4, 15, 16'd60,   8'd255, ihv_pkg::PROTO_TCP,  CK_GOOD, FILL_RAND, 1,
      ihv_pkg::ST_OK},
    '{28, 4, 5,  16'd28,   8'd64,  ihv_pkg::PROTO_UDP,  CK_BAD,  FILL_RAND, 1,
      ihv_pkg::ST_CHECKSUM},
    '{28, 4, 5,  16'd29,   8'd64,  ihv_pkg::PROTO_UDP,  CK_GOOD, FILL_RAND, 1,
      ihv_pkg::ST_TRUNCATED},
    '{30, 4, 5,  16'hFFFF, 8'd64,  ihv_pkg::PROTO_ICMP, CK_GOOD, FILL_RAND, 1,
      ihv_pkg::ST_TRUNCATED},
    '{20, 4, 5,  16'd20,   8'd0,   ihv_pkg::PROTO_ICMP, CK_GOOD, FILL_RAND, 1,
      ihv_pkg::ST_TTL},
    '{20, 4, 5,  16'd20,   8'd1,   8'd99,               CK_GOOD, FILL_RAND, 1,
      ihv_pkg::ST_PROTOCOL},
    '{20, 4, 5,  16'd20,   8'd1,   8'd0,                CK_GOOD, FILL_RAND, 1,
      ihv_pkg::ST_PROTOCOL},
    '{20, 4, 5,  16'd10,   8'd128, ihv_pkg::PROTO_ICMP, CK_GOOD, FILL_RAND, 0,
      ihv_pkg::ST_OK},
    '{36, 4, 5,  16'd30,   8'd64,  ihv_pkg::PROTO_UDP,  CK_GOOD, FILL_RAND, 0,
      ihv_pkg::ST_OK},
    '{20, 15, 15, 16'hFFFF, 8'hFF, 8'hFF,               CK_ASIS, FILL_ONES, 1,
      ihv_pkg::ST_VERSION},
    '{20, 0, 0,  16'd0,    8'd0,   8'd0,                CK_ASIS, FILL_ZERO, 1,
      ihv_pkg::ST_VERSION},
    '{1,  15, 15, 16'hFFFF, 8'hFF, 8'hFF,               CK_ASIS, FILL_ONES, 1,
      ihv_pkg::ST_SHORT},
    '{20, 4, 5,  16'd20,   8'd64,  ihv_pkg::PROTO_TCP,  CK_GOOD, FILL_RAND, 1,
      ihv_pkg::ST_OK},
    '{24, 4, 6,  16'd24,   8'd64,  ihv_pkg::PROTO_UDP,  CK_GOOD, FILL_RAND, 1,
      ihv_pkg::ST_OK}
  };

  ipv4_header_validator_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_last_byte       (in_last_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_protocol_class (out_protocol_class),
    .out_header_bytes   (out_header_bytes),
    .out_payload_length (out_payload_length)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic clear_packet_state();
    cnt_q   = '0;
    vihl_q  = '0;
    sum_q   = '0;
    hold_q  = '0;
    csum_q  = '0;
    tot_q   = '0;
    ttl_q   = '0;
    proto_q = '0;
  endtask

  // byte-level validator model; queues a verdict on the last byte
  task automatic absorb_byte(input logic [7:0] b, input logic last);
    logic [15:0] pos;
    logic [7:0]  v;
    logic [5:0]  hb;
    logic [16:0] f1;
    logic [16:0] f2;
    logic [15:0] calc;
    verdict_t    vd;
    pkt_note_t   note;
    pos = cnt_q;
    if (pos == ihv_pkg::POS_VIHL) begin
      vihl_q = b;
    end
    hb = {vihl_q[3:0], 2'b00};
    if (pos < {10'd0, hb}) begin
      v = (pos == ihv_pkg::POS_CSUM_HI || pos == ihv_pkg::POS_CSUM_LO) ? 8'h00 : b;
      if (!pos[0]) begin
        hold_q = v;
      end else begin
        sum_q = sum_q + {5'd0, hold_q, v};
      end
    end
    case (pos)
      ihv_pkg::POS_TOT_HI:  tot_q[15:8]  = b;
      ihv_pkg::POS_TOT_LO:  tot_q[7:0]   = b;
      ihv_pkg::POS_TTL:     ttl_q        = b;
      ihv_pkg::POS_PROTO:   proto_q      = b;
      ihv_pkg::POS_CSUM_HI: csum_q[15:8] = b;
      ihv_pkg::POS_CSUM_LO: csum_q[7:0]  = b;
      default: ;
    endcase
    if (cnt_q != ihv_pkg::COUNT_MAX) begin
      cnt_q = cnt_q + 16'd1;
    end
    if (last) begin
      f1 = {1'b0, sum_q[15:0]} + {12'd0, sum_q[20:16]};
      f2 = {1'b0, f1[15:0]} + {16'd0, f1[16]};
      calc = ~f2[15:0];
      if (proto_q == ihv_pkg::PROTO_ICMP) begin
        vd.pclass = ihv_pkg::PC_ICMP;
      end else if (proto_q == ihv_pkg::PROTO_UDP) begin
        vd.pclass = ihv_pkg::PC_UDP;
      end else if (proto_q == ihv_pkg::PROTO_TCP) begin
        vd.pclass = ihv_pkg::PC_TCP;
      end else begin
        vd.pclass = ihv_pkg::PC_NONE;
      end
      if (cnt_q < ihv_pkg::MIN_HEADER_BYTES) begin
        vd.status = ihv_pkg::ST_SHORT;
      end else if (vihl_q[7:4] != ihv_pkg::IP_VERSION) begin
        vd.status = ihv_pkg::ST_VERSION;
      end else if (vihl_q[3:0] < ihv_pkg::IHL_MIN) begin
        vd.status = ihv_pkg::ST_IHL;
      end else if (cnt_q < {10'd0, hb}) begin
        vd.status = ihv_pkg::ST_HDR_CUT;
      end else if (calc != csum_q) begin
        vd.status = ihv_pkg::ST_CHECKSUM;
      end else if (tot_q > cnt_q) begin
        vd.status = ihv_pkg::ST_TRUNCATED;
      end else if (ttl_q == 8'd0) begin
        vd.status = ihv_pkg::ST_TTL;
      end else if (vd.pclass == ihv_pkg::PC_NONE) begin
        vd.status = ihv_pkg::ST_PROTOCOL;
      end else begin
        vd.status = ihv_pkg::ST_OK;
      end
      vd.hbytes  = hb;
      vd.payload = (tot_q >= {10'd0, hb}) ? tot_q - {10'd0, hb} : 16'd0;
      if (pkt_notes.size() > 0) begin
        note = pkt_notes.pop_front();
        if (note.typed) begin
          vd.status = note.st;
        end
      end
      status_seen[vd.status]++;
      verdicts_due.push_back(vd);
      clear_packet_state();
    end
  endtask

  always @(posedge clk) begin : scoreboard
    verdict_t exp_v;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d verdicts still due", $time, verdicts_due.size());
      $display("** ipv4_header_validator_core: FAILED **");
      $finish;
    end else if (rst_n) begin
      if (in_valid && !in_stall) begin
        absorb_byte(in_data_byte, in_last_byte);
      end
      if (out_valid && !out_stall) begin
        if (verdicts_due.size() == 0) begin
          errors++;
          $display("%0t: expected no verdict, got status %0d", $time, out_status);
        end else begin
          exp_v = verdicts_due.pop_front();
          verdicts_checked++;
          if (out_status !== exp_v.status) begin
            errors++;
            $display("%0t: status expected %0d, got %0d", $time, exp_v.status, out_status);
          end
          if (out_protocol_class !== exp_v.pclass) begin
            errors++;
            $display("%0t: protocol_class expected %0d, got %0d", $time, exp_v.pclass,
                     out_protocol_class);
          end
          if (out_header_bytes !== exp_v.hbytes) begin
            errors++;
            $display("%0t: header_bytes expected %0d, got %0d", $time, exp_v.hbytes,
                     out_header_bytes);
          end
          if (out_payload_length !== exp_v.payload) begin
            errors++;
            $display("%0t: payload_length expected %0d, got %0d", $time, exp_v.payload,
                     out_payload_length);
          end
        end
      end
    end
  end

  // result side back-pressure
  initial begin
    forever begin
      @(posedge clk);
      if (!calm && rst_n && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_packet(input pkt_spec_t s);
    logic [7:0]  pkt[$];
    logic [31:0] acc;
    logic [15:0] ck;
    logic [7:0]  hi;
    logic [7:0]  lo;
    int          hb;
    int          i;
    pkt_note_t   note;
    for (i = 0; i < s.plen; i++) begin
      case (s.fill)
        FILL_ZERO: pkt.push_back(8'h00);
        FILL_ONES: pkt.push_back(8'hFF);
        default:   pkt.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    pkt[0] = {s.ver, s.ihl};
    if (s.plen > 3) begin
      pkt[2] = s.tot[15:8];
      pkt[3] = s.tot[7:0];
    end
    if (s.plen > 9) begin
      pkt[8] = s.ttl;
      pkt[9] = s.proto;
    end
    hb  = int'(s.ihl) * 4;
    acc = '0;
    for (i = 0; i < hb; i += 2) begin
      if (i != 10) begin
        hi  = (i < s.plen) ? pkt[i] : 8'h00;
        lo  = (i + 1 < s.plen) ? pkt[i + 1] : 8'h00;
        acc = acc + {16'd0, hi, lo};
      end
    end
    acc = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
    acc = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
    ck  = ~acc[15:0];
    if (s.ck == CK_BAD) begin
      ck = ck ^ 16'($urandom_range(1, 65535));
    end
    if (s.plen > 11 && s.ck != CK_ASIS) begin
      pkt[10] = ck[15:8];
      pkt[11] = ck[7:0];
    end
    note.typed = s.typed;
    note.st    = s.st;
    pkt_notes.push_back(note);
    for (i = 0; i < s.plen; i++) begin
      send_byte(pkt[i], i == s.plen - 1);
    end
    packets_sent++;
  endtask

  function automatic pkt_spec_t random_spec();
    pkt_spec_t s;
    int        k;
    s.fill  = FILL_RAND;
    s.typed = 1'b0;
    s.st    = ihv_pkg::ST_OK;
    s.ck    = CK_GOOD;
    s.ver   = ihv_pkg::IP_VERSION;
    s.ihl   = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(6, 15)) : ihv_pkg::IHL_MIN;
    s.plen  = int'(s.ihl) * 4 + $urandom_range(0, 24);
    s.tot   = 16'(s.plen - $urandom_range(0, 3) * $urandom_range(0, 1));
    s.ttl   = 8'($urandom_range(1, 255));
    case ($urandom_range(0, 2))
      0:       s.proto = ihv_pkg::PROTO_ICMP;
      1:       s.proto = ihv_pkg::PROTO_UDP;
      default: s.proto = ihv_pkg::PROTO_TCP;
    endcase
    k = $urandom_range(0, 99);
    if (k < 6) begin
      s.ver = 4'($urandom_range(0, 15));
    end else if (k < 12) begin
      s.ihl = 4'($urandom_range(0, 15));
    end else if (k < 20) begin
      s.ck = CK_BAD;
    end else if (k < 26) begin
      s.tot = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, s.plen + 2));
    end else if (k < 30) begin
      s.ttl = 8'd0;
    end else if (k < 36) begin
      s.proto = 8'($urandom_range(0, 255));
    end else if (k < 42) begin
      s.plen = $urandom_range(1, int'(s.ihl) * 4 + 4);
    end else if (k < 48) begin
      s.ver   = 4'($urandom_range(0, 15));
      s.ihl   = 4'($urandom_range(0, 15));
      s.plen  = $urandom_range(1, 70);
      s.tot   = 16'($urandom);
      s.ttl   = 8'($urandom_range(0, 255));
      s.proto = 8'($urandom_range(0, 255));
      s.ck    = CK_ASIS;
    end
    return s;
  endfunction

  initial begin : stimulus
    int                   start_bytes;
    string                seen;
    ihv_pkg::ihv_status_t st_e;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_data_byte <= 8'h00;
    in_last_byte <= 1'b0;
    out_stall    <= 1'b0;
    clear_packet_state();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      send_packet(directed_rows[r]);
    end

    start_bytes = bytes_sent;
    while (bytes_sent - start_bytes < RANDOM_BYTES) begin
      if (bytes_sent - start_bytes >= RANDOM_BYTES - CALM_BYTES) begin
        calm = 1'b1;
      end
      send_packet(random_spec());
    end
    in_valid <= 1'b0;

    while (verdicts_due.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    seen = "";
    for (int st = 0; st <= ihv_pkg::ST_PROTOCOL; st++) begin
      st_e = ihv_pkg::ihv_status_t'(st);
      seen = {seen, $sformatf(" %s=%0d", st_e.name(), status_seen[st])};
    end
    $display("Ran %0d packets (%0d bytes), %0d verdicts compared, %0d mismatches",
             packets_sent, bytes_sent, verdicts_checked, errors);
    $display("Verdicts by status:%s", seen);
    if (errors == 0) begin
      $display("** ipv4_header_validator_core: PASSED **");
    end else begin
      $display("** ipv4_header_validator_core: FAILED **");
    end
    $finish;
  end

endmodule
